### hw/rtl/s2w_pkg.sv
// ----------------------------------------------------------------------------
// s2w_pkg
// Types and constants shared by the screen-to-world unprojection block.
// ----------------------------------------------------------------------------
package s2w_pkg;

	localparam int LANE_BITS  = 16;
	localparam int NDC_FRAC   = 20;
	localparam int DEPTH_FRAC = 14;
	localparam int Q_FRAC     = 16;
	localparam int SCALE_BITS = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int NDC_W      = 34;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd5;

	localparam logic [CFG_DATA_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [CFG_DATA_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;
	localparam logic [SCALE_BITS-1:0] X_SCALE_RESET = 17'd205;
	localparam logic [SCALE_BITS-1:0] Y_SCALE_RESET = 17'd273;

	typedef struct packed {
		logic [15:0]        pix_x;
		logic [15:0]        pix_y;
		logic signed [15:0] depth_ndc;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic               degenerate;
	} out_word_t;

endpackage

### hw/rtl/s2w_div.sv
// ----------------------------------------------------------------------------
// s2w_div
// Pipelined signed divider, several numerators over one shared divisor,
// one quotient bit per stage, Q.16 result truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module s2w_div #(
	parameter int ACC_W = 52,
	parameter int OB    = 32,
	parameter int NL    = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [ACC_W-1:0] num [NL],
	input  logic signed [ACC_W-1:0] den,
	output logic                    out_valid,
	output logic signed [OB-1:0]    res [NL],
	output logic                    flag
);

	localparam int NW = ACC_W + s2w_pkg::Q_FRAC;
	localparam int SH = OB - s2w_pkg::Q_FRAC;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic npos;
		logic nneg;
	} lane_t;

	logic               v_q   [OB+1];
	logic [ACC_W-1:0]   ud_q  [OB+1];
	logic               zero_q[OB+1];
	lane_t              ln_q  [OB+1][NL];
	logic [ACC_W-1:0]   rem_q [OB+1][NL];
	logic [OB-1:0]      low_q [OB+1][NL];
	logic [OB-1:0]      quo_q [OB+1][NL];

	logic [ACC_W-1:0] ud_c;
	logic [ACC_W-1:0] un_c [NL];
	logic [NW-1:0]    nn_c [NL];

	always_comb begin
		ud_c = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
		for (int l = 0; l < NL; l++) begin
			un_c[l] = num[l][ACC_W-1] ? ACC_W'(-num[l]) : ACC_W'(num[l]);
			nn_c[l] = {un_c[l], {s2w_pkg::Q_FRAC{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= OB; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int k = 0; k < OB; k++) v_q[k+1] <= v_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ud_q[0]   <= ud_c;
			zero_q[0] <= (den == '0);
			for (int l = 0; l < NL; l++) begin
				ln_q[0][l].neg  <= num[l][ACC_W-1] ^ den[ACC_W-1];
				ln_q[0][l].ovf  <= (un_c[l] >> SH) >= ud_c;
				ln_q[0][l].npos <= !num[l][ACC_W-1] && (num[l] != '0);
				ln_q[0][l].nneg <= num[l][ACC_W-1];
				rem_q[0][l]     <= ACC_W'(nn_c[l] >> OB);
				low_q[0][l]     <= nn_c[l][OB-1:0];
				quo_q[0][l]     <= '0;
			end
		end
	end

	for (genvar k = 0; k < OB; k++) begin : g_step
		logic [ACC_W:0] t   [NL];
		logic           ge  [NL];
		always_comb begin
			for (int l = 0; l < NL; l++) begin
				t[l]  = {rem_q[k][l], low_q[k][l][OB-1]};
				ge[l] = t[l] >= {1'b0, ud_q[k]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ud_q[k+1]   <= ud_q[k];
				zero_q[k+1] <= zero_q[k];
				for (int l = 0; l < NL; l++) begin
					ln_q[k+1][l]  <= ln_q[k][l];
					rem_q[k+1][l] <= ge[l] ? ACC_W'(t[l] - {1'b0, ud_q[k]}) : ACC_W'(t[l]);
					low_q[k+1][l] <= low_q[k][l] << 1;
					quo_q[k+1][l] <= {quo_q[k][l][OB-2:0], ge[l]};
				end
			end
		end
	end

	localparam logic signed [OB-1:0] MAXV = {1'b0, {(OB-1){1'b1}}};
	localparam logic signed [OB-1:0] MINV = {1'b1, {(OB-1){1'b0}}};

	logic signed [OB-1:0] res_c [NL];
	logic                 sat_c [NL];
	logic [OB:0]          lim_c [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lim_c[l] = ln_q[OB][l].neg ? (OB+1)'({1'b1, {(OB-1){1'b0}}})
			                           : (OB+1)'(MAXV);
			sat_c[l] = ln_q[OB][l].ovf || ({1'b0, quo_q[OB][l]} > lim_c[l]);
			if (zero_q[OB]) begin
				res_c[l] = ln_q[OB][l].npos ? MAXV : (ln_q[OB][l].nneg ? MINV : '0);
			end else if (sat_c[l]) begin
				res_c[l] = ln_q[OB][l].neg ? MINV : MAXV;
			end else begin
				res_c[l] = ln_q[OB][l].neg ? -$signed(quo_q[OB][l]) : $signed(quo_q[OB][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_q[OB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag <= zero_q[OB] || sat_c[0] || sat_c[1] || sat_c[NL-1];
			for (int l = 0; l < NL; l++) res[l] <= res_c[l];
		end
	end

endmodule

### hw/rtl/screen_to_world_unproject_top.sv
// ----------------------------------------------------------------------------
// screen_to_world_unproject_top
// Unprojects a screen point through an inverse view-projection matrix.
// ----------------------------------------------------------------------------
// Input words (pix_x, pix_y, depth_ndc) arrive on in_valid/in_ready;
// each gives one output word (world_x/y/z in Q16.16, degenerate) on
// out_valid/out_ready. Configuration words go in on cfg_valid/cfg_ready
// with a register index: 0..3 matrix rows, 4 x_scale, 5 y_scale; other
// indexes are dropped. Write configuration only while the pipeline is empty.
// Three stages serve NDC mapping, matrix products and row sums, then a
// divider resolves one quotient bit per stage, plus its setup and output
// stages. One word enters per cycle while out_ready is high. When the
// receiver stalls, the whole pipeline holds and in_ready drops; nothing
// is lost or repeated. Reset loads the identity matrix and default scales
// and empties the pipeline.
// ----------------------------------------------------------------------------
module screen_to_world_unproject_top #(
	parameter int COEF_BITS = 16,
	parameter int OUT_BITS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  s2w_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output s2w_pkg::out_word_t                   out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [s2w_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [s2w_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CW     = (COEF_BITS > s2w_pkg::LANE_BITS) ? s2w_pkg::LANE_BITS : COEF_BITS;
	localparam int NDC_W  = s2w_pkg::NDC_W;
	localparam int PROD_W = CW + NDC_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SB     = s2w_pkg::SCALE_BITS;

	logic [s2w_pkg::CFG_DATA_W-1:0] row_q [4];
	logic [SB-1:0]                  xs_q;
	logic [SB-1:0]                  ys_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= s2w_pkg::ROW0_RESET;
			row_q[1] <= s2w_pkg::ROW1_RESET;
			row_q[2] <= s2w_pkg::ROW2_RESET;
			row_q[3] <= s2w_pkg::ROW3_RESET;
			xs_q     <= s2w_pkg::X_SCALE_RESET;
			ys_q     <= s2w_pkg::Y_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				s2w_pkg::REG_ROW0:    row_q[0] <= cfg_data;
				s2w_pkg::REG_ROW1:    row_q[1] <= cfg_data;
				s2w_pkg::REG_ROW2:    row_q[2] <= cfg_data;
				s2w_pkg::REG_ROW3:    row_q[3] <= cfg_data;
				s2w_pkg::REG_X_SCALE: xs_q     <= cfg_data[SB-1:0];
				s2w_pkg::REG_Y_SCALE: ys_q     <= cfg_data[SB-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [NDC_W-1:0]  ndc_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [4][4];
	logic signed [ACC_W-1:0]  acc_s3 [4];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	localparam logic signed [NDC_W-1:0] ONE = NDC_W'(1) <<< s2w_pkg::NDC_FRAC;

	logic [32:0] px_c, py_c;
	assign px_c = in_data.pix_x * xs_q;
	assign py_c = in_data.pix_y * ys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ndc_s1[0] <= $signed(NDC_W'(px_c)) - ONE;
			ndc_s1[1] <= ONE - $signed(NDC_W'(py_c));
			ndc_s1[2] <= NDC_W'(in_data.depth_ndc) <<< (s2w_pkg::NDC_FRAC - s2w_pkg::DEPTH_FRAC);
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			logic signed [CW-1:0] cf;
			assign cf = $signed(row_q[r][c*s2w_pkg::LANE_BITS +: CW]);
			if (c < 3) begin : g_mul
				always_ff @(posedge clk) begin
					if (en) prod_s2[r][c] <= PROD_W'(cf) * PROD_W'(ndc_s1[c]);
				end
			end else begin : g_w
				always_ff @(posedge clk) begin
					if (en) prod_s2[r][c] <= PROD_W'(cf) <<< s2w_pkg::NDC_FRAC;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s3[r] <= ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1])
				           + ACC_W'(prod_s2[r][2]) + ACC_W'(prod_s2[r][3]);
			end
		end
	end

	logic signed [ACC_W-1:0]    num_c [3];
	logic signed [OUT_BITS-1:0] res   [3];
	logic                       flag;

	assign num_c[0] = acc_s3[0];
	assign num_c[1] = acc_s3[1];
	assign num_c[2] = acc_s3[2];

	s2w_div #(
		.ACC_W (ACC_W),
		.OB    (OUT_BITS),
		.NL    (3)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num_c),
		.den       (acc_s3[3]),
		.out_valid (out_valid),
		.res       (res),
		.flag      (flag)
	);

	logic signed [63:0] wx, wy, wz;
	assign wx = 64'(res[0]);
	assign wy = 64'(res[1]);
	assign wz = 64'(res[2]);

	assign out_data.world_x    = wx[31:0];
	assign out_data.world_y    = wy[31:0];
	assign out_data.world_z    = wz[31:0];
	assign out_data.degenerate = flag;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word did not enter stage 1");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s1 |=> v_s1 && $stable(ndc_s1[0]) && $stable(ndc_s1[1]))
		else $error("stage 1 changed during stall");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s3 |=> v_s3 && $stable(acc_s3[3]))
		else $error("stage 3 changed during stall");

endmodule

### dv/screen_to_world_unproject_top_tb.sv
// ----------------------------------------------------------------------------
// screen_to_world_unproject_top_tb
// Streams screen points through the unprojection block under random idling
// on both sides and checks every world-space word against a predictor of
// the NDC mapping, matrix product and saturating divide by w.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module screen_to_world_unproject_top_tb;

	localparam int LATENCY_WAIT = 45;
	localparam int IDX_W = s2w_pkg::CFG_IDX_W;
	localparam int SB = s2w_pkg::SCALE_BITS;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint NDC_ONE = 64'sd1 << s2w_pkg::NDC_FRAC;
	localparam longint Q_MAX = (64'sd1 << 31) - 1;
	localparam longint Q_MIN = -(64'sd1 << 31);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	s2w_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	s2w_pkg::out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [s2w_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [63:0] mat_row[4];
	logic [SB-1:0] x_scale_q;
	logic [SB-1:0] y_scale_q;
	s2w_pkg::out_word_t world_pending[$];
	int fail_count;
	int rx_hold_cycles;
	bit no_gaps;

	screen_to_world_unproject_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	initial begin
		#2000000;
		$display("screen_to_world_unproject_top_tb NOT OK");
		$finish;
	end

	function automatic longint div_by_w(longint n, longint d, inout bit flag);
		longint unsigned un, ud, iq, r, f, lim, mag;
		bit neg;
		neg = (n < 0) != (d < 0);
		if (d == 0) begin
			flag = 1'b1;
			return (n > 0) ? Q_MAX : ((n < 0) ? Q_MIN : 0);
		end
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		iq = un / ud;
		r = un % ud;
		f = 0;
		lim = neg ? Q_MAX + 1 : Q_MAX;
		if (iq > (lim >> s2w_pkg::Q_FRAC)) begin
			flag = 1'b1;
			return neg ? Q_MIN : Q_MAX;
		end
		for (int i = 0; i < s2w_pkg::Q_FRAC; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= ud) begin
				r = r - ud;
				f = f | 1;
			end
		end
		mag = (iq << s2w_pkg::Q_FRAC) | f;
		if (mag > lim) begin
			flag = 1'b1;
			return neg ? Q_MIN : Q_MAX;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic s2w_pkg::out_word_t unproject(s2w_pkg::in_word_t w);
		longint ndc[4];
		longint acc[4];
		longint q[3];
		bit flag;
		s2w_pkg::out_word_t o;
		flag = 1'b0;
		ndc[0] = longint'(w.pix_x) * longint'(x_scale_q) - NDC_ONE;
		ndc[1] = NDC_ONE - longint'(w.pix_y) * longint'(y_scale_q);
		ndc[2] = longint'(w.depth_ndc)
			* (64'sd1 << (s2w_pkg::NDC_FRAC - s2w_pkg::DEPTH_FRAC));
		ndc[3] = NDC_ONE;
		for (int r = 0; r < 4; r++) begin
			acc[r] = 0;
			for (int c = 0; c < 4; c++)
				acc[r] += longint'($signed(mat_row[r][16*c +: 16])) * ndc[c];
		end
		for (int r = 0; r < 3; r++)
			q[r] = div_by_w(acc[r], acc[3], flag);
		o.world_x = q[0][31:0];
		o.world_y = q[1][31:0];
		o.world_z = q[2][31:0];
		o.degenerate = flag;
		return o;
	endfunction

	// receiver: stall per word, or one long hold-off when requested
	initial begin
		int stall;
		s2w_pkg::out_word_t exp_w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else
				stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (world_pending.size() == 0) begin
				$error("unexpected output word %h", out_data);
				fail_count++;
			end else begin
				exp_w = world_pending.pop_front();
				if (out_data.world_x !== exp_w.world_x) begin
					$error("world_x exp %h got %h", exp_w.world_x, out_data.world_x);
					fail_count++;
				end
				if (out_data.world_y !== exp_w.world_y) begin
					$error("world_y exp %h got %h", exp_w.world_y, out_data.world_y);
					fail_count++;
				end
				if (out_data.world_z !== exp_w.world_z) begin
					$error("world_z exp %h got %h", exp_w.world_z, out_data.world_z);
					fail_count++;
				end
				if (out_data.degenerate !== exp_w.degenerate) begin
					$error("degenerate exp %b got %b", exp_w.degenerate,
						out_data.degenerate);
					fail_count++;
				end
			end
		end
	end

	task automatic send_point(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] dz);
		int gap;
		s2w_pkg::in_word_t w;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		w.pix_x = sx;
		w.pix_y = sy;
		w.depth_ndc = dz;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		world_pending.push_back(unproject(w));
	endtask

	task automatic send_random_point();
		send_point(16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (world_pending.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			s2w_pkg::REG_ROW0: mat_row[0] = val;
			s2w_pkg::REG_ROW1: mat_row[1] = val;
			s2w_pkg::REG_ROW2: mat_row[2] = val;
			s2w_pkg::REG_ROW3: mat_row[3] = val;
			s2w_pkg::REG_X_SCALE: x_scale_q = val[SB-1:0];
			s2w_pkg::REG_Y_SCALE: y_scale_q = val[SB-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// lane values kept small enough that w rarely vanishes or overflows
	function automatic logic [63:0] tame_row();
		logic [63:0] v;
		for (int c = 0; c < 4; c++)
			v[16*c +: 16] = 16'($signed($urandom_range(0, 16384)) - 8192);
		return v;
	endfunction

	task automatic test_directed();
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF, 16'h7FFF);
		send_point(16'h0000, 16'hFFFF, 16'h8000);
		send_point(16'hFFFF, 16'h0000, 16'hFFFF);
		send_point(16'h1400, 16'h0F00, 16'h2000);
		drain();
		// zero w row: each coordinate saturates by numerator sign, or is zero for a zero numerator
		write_reg(s2w_pkg::REG_ROW3, 64'h0);
		send_point(16'h0000, 16'h0000, 16'h4000);
		send_point(16'h1400, 16'h0F00, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF, 16'hC000);
		drain();
		// tiny w, huge numerators: quotient overflow
		write_reg(s2w_pkg::REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(s2w_pkg::REG_ROW1, 64'h8000_8000_8000_8000);
		write_reg(s2w_pkg::REG_ROW3, 64'h0001_0000_0000_0000);
		write_reg(s2w_pkg::REG_X_SCALE, 64'h1_FFFF);
		write_reg(s2w_pkg::REG_Y_SCALE, 64'h0);
		send_point(16'hFFFF, 16'h1234, 16'h7FFF);
		send_point(16'h0000, 16'hFFFF, 16'h8000);
		send_point(16'h0010, 16'h0000, 16'h0001);
		send_point(16'h8000, 16'h8000, 16'h0000);
		drain();
		// spare indexes must leave the registers alone
		write_reg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_HI, 64'h0);
		write_reg(s2w_pkg::REG_ROW2, 64'h8000_7FFF_0001_FFFF);
		write_reg(s2w_pkg::REG_ROW3, 64'hF000_0000_0000_0000);
		send_point(16'h0800, 16'h0800, 16'h8000);
		send_point(16'hFFFF, 16'h0000, 16'h7FFF);
		send_point(16'h0000, 16'h0000, 16'h0000);
		drain();
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 4; r++)
				write_reg(IDX_W'(r), (ph % 3 == 2) ? {$urandom, $urandom} : tame_row());
			if (ph == 1) begin
				write_reg(s2w_pkg::REG_X_SCALE, 64'h0);
				write_reg(s2w_pkg::REG_Y_SCALE, 64'h1_FFFF);
			end else begin
				write_reg(s2w_pkg::REG_X_SCALE, {$urandom, $urandom});
				write_reg(s2w_pkg::REG_Y_SCALE, 64'($urandom_range(0, 2048)));
			end
			no_gaps = (ph == 3);
			for (int i = 0; i < 150; i++) begin
				if (ph == 4 && i == 75)
					drain();
				send_random_point();
			end
			no_gaps = 1'b0;
			drain();
		end
	endtask

	task automatic test_backpressure();
		rx_hold_cycles = 300;
		no_gaps = 1'b1;
		for (int i = 0; i < 60; i++)
			send_random_point();
		no_gaps = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		rx_hold_cycles = 0;
		no_gaps = 1'b0;
		mat_row[0] = s2w_pkg::ROW0_RESET;
		mat_row[1] = s2w_pkg::ROW1_RESET;
		mat_row[2] = s2w_pkg::ROW2_RESET;
		mat_row[3] = s2w_pkg::ROW3_RESET;
		x_scale_q = s2w_pkg::X_SCALE_RESET;
		y_scale_q = s2w_pkg::Y_SCALE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_configs();
		test_backpressure();
		if (fail_count == 0)
			$display("screen_to_world_unproject_top_tb OK");
		else
			$display("screen_to_world_unproject_top_tb NOT OK");
		$finish;
	end

endmodule
